// ===== src/cset_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the call stack exclusive-time profiler.
// No dependencies; used by cset_totals and call_stack_exclusive_time.
package cset_pkg;

  localparam int OPCODE_W  = 2;
  localparam int FID_W     = 6;
  localparam int TIME_W    = 31;
  localparam int TOTAL_W   = 48;
  localparam int STATUS_W  = 2;
  // time difference plus one, signed
  localparam int DELTA_W   = TIME_W + 2;
  // function id widened to cover any totals depth up to 1024
  localparam int FID_EXT_W = 11;

  localparam int DEF_NUM_FUNCS   = 64;
  localparam int DEF_STACK_DEPTH = 64;

  localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_END   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [FID_W-1:0]    func_id;
    logic [TIME_W-1:0]   event_time;
  } in_item_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_time;
    logic [STATUS_W-1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [FID_W-1:0]  func;
    logic [TIME_W-1:0] start;
  } frame_t;

  // Totals store access: read, and add delta to the last value read.
  typedef struct packed {
    logic                      rd_en;
    logic [FID_EXT_W-1:0]      rd_addr;
    logic                      wr_en;
    logic [FID_EXT_W-1:0]      wr_addr;
    logic signed [DELTA_W-1:0] delta;
  } tot_req_t;

endpackage

// ===== src/cset_totals.sv =====
`timescale 1ns / 1ps
// Per-function totals memory: clearing sweep after reset, registered read,
// saturating add of a signed delta onto the last read value. Uses cset_pkg.
module cset_totals #(
  parameter int NUM_FUNCS = cset_pkg::DEF_NUM_FUNCS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cset_pkg::tot_req_t                 req,
  output logic signed [cset_pkg::TOTAL_W-1:0] rd_data,
  output logic                               busy
);
  import cset_pkg::*;

  localparam int AW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_FUNCS - 1);

  logic signed [TOTAL_W-1:0] mem [NUM_FUNCS];
  logic signed [TOTAL_W-1:0] rd_q_r;
  logic signed [TOTAL_W:0]   wide;
  logic signed [TOTAL_W-1:0] sum;
  logic [AW-1:0]             raddr, waddr;
  logic [AW-1:0]             clr_idx_r, clr_idx_nxt;
  logic                      busy_r, busy_nxt;

  assign raddr   = req.rd_addr[AW-1:0];
  assign waddr   = req.wr_addr[AW-1:0];
  assign rd_data = rd_q_r;
  assign busy    = busy_r;

  always_comb begin
    wide = {rd_q_r[TOTAL_W-1], rd_q_r} + (TOTAL_W+1)'(req.delta);
    if (wide[TOTAL_W] != wide[TOTAL_W-1]) begin
      sum = wide[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      sum = wide[TOTAL_W-1:0];
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    clr_idx_nxt = clr_idx_r;
    if (busy_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr_en) begin
      mem[waddr] <= sum;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[raddr];
    end
  end

endmodule

// ===== src/call_stack_exclusive_time.sv =====
`timescale 1ns / 1ps
// Top level of the exclusive-time profiler: stack memory and sequencer.
// Depends on cset_pkg and cset_totals.

// Each transaction is one parsed trace event and returns one result. After
// reset the totals memory is swept to zero, during which no transaction is
// accepted. The sequencer then works on one item at a time, stepping through
// the stack and totals memories, each with a registered read. A read, a
// dropped/ignored event or a start on an empty stack goes from idle via
// S_FIN_RD to S_FIN_OUT; a start with a frame below it or an end event that
// empties the stack first passes S_STK_USE and S_TOT_ADD, an end event that
// charges the parent back passes them twice, and S_FIN_OUT waits on out_ready.
// Frames are in a STACK_DEPTH-entry memory, totals in a NUM_FUNCS-entry memory.
module call_stack_exclusive_time #(
  parameter int NUM_FUNCS   = cset_pkg::DEF_NUM_FUNCS,
  parameter int STACK_DEPTH = cset_pkg::DEF_STACK_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cset_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cset_pkg::out_item_t out_data
);
  import cset_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [FID_EXT_W-1:0] NF = FID_EXT_W'(NUM_FUNCS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STK_USE,
    S_TOT_ADD,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;
  logic [OPCODE_W-1:0]       op_r, op_nxt;
  logic [FID_W-1:0]          fid_r, fid_nxt;
  logic [TIME_W-1:0]         t_r, t_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic                      phase_r, phase_nxt;
  logic [FID_W-1:0]          tgt_r, tgt_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;

  // stack memory
  frame_t        stk_mem [STACK_DEPTH];
  frame_t        stk_q_r;
  frame_t        stk_wdata;
  logic          stk_we, stk_re;
  logic [SW-1:0] stk_waddr, stk_raddr;

  tot_req_t                  tot_req;
  logic signed [TOTAL_W-1:0] tot_rd_data;
  logic                      tot_busy;

  logic [CW-1:0]             cnt_m1, cnt_m2;
  logic [FID_EXT_W-1:0]      fid_ext, tgt_ext, frame_fid_ext;
  logic                      accept;
  logic signed [DELTA_W-1:0] t_s, start_s;

  cset_totals #(
    .NUM_FUNCS(NUM_FUNCS)
  ) u_totals (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (tot_req),
    .rd_data(tot_rd_data),
    .busy   (tot_busy)
  );

  assign in_ready  = (state_r == S_IDLE) && !tot_busy;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cnt_m1        = count_r - CW'(1);
  assign cnt_m2        = count_r - CW'(2);
  assign fid_ext       = FID_EXT_W'(fid_r);
  assign tgt_ext       = FID_EXT_W'(tgt_r);
  assign frame_fid_ext = FID_EXT_W'(stk_q_r.func);
  assign t_s           = DELTA_W'({2'b00, t_r});
  assign start_s       = DELTA_W'({2'b00, stk_q_r.start});

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    fid_nxt       = fid_r;
    t_nxt         = t_r;
    status_nxt    = status_r;
    phase_nxt     = phase_r;
    tgt_nxt       = tgt_r;
    delta_nxt     = delta_r;

    stk_we    = 1'b0;
    stk_waddr = count_r[SW-1:0];
    stk_wdata = frame_t'({fid_r, t_r});
    stk_re    = 1'b0;
    stk_raddr = cnt_m1[SW-1:0];

    tot_req         = '0;
    tot_req.rd_addr = tgt_ext;
    tot_req.wr_addr = tgt_ext;
    tot_req.delta   = delta_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.opcode;
          fid_nxt    = in_data.func_id;
          t_nxt      = in_data.event_time;
          status_nxt = ST_OK;
          phase_nxt  = 1'b0;
          state_nxt  = S_FIN_RD;
          case (in_data.opcode)
            OP_START: begin
              if (count_r == FULL_CNT) begin
                status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                stk_we    = 1'b1;
                stk_wdata = frame_t'({in_data.func_id, in_data.event_time});
                count_nxt = count_r + CW'(1);
              end else begin
                stk_re    = 1'b1;
                state_nxt = S_STK_USE;
              end
            end
            OP_END: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                stk_re    = 1'b1;
                state_nxt = S_STK_USE;
              end
            end
            default: ;  // read, and the unused code acts as a read
          endcase
        end
      end

      S_STK_USE: begin
        if (op_r == OP_START) begin
          // charge the caller up to now, then push the new frame
          delta_nxt = t_s - start_s;
          tgt_nxt   = stk_q_r.func;
          stk_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end else if (!phase_r) begin
          delta_nxt = t_s - start_s + DELTA_W'(1);
          tgt_nxt   = fid_r;
        end else begin
          // parent gives back its span from its start through the callee's end
          delta_nxt = start_s - t_s - DELTA_W'(1);
          tgt_nxt   = stk_q_r.func;
        end
        tot_req.rd_addr = (op_r == OP_END && !phase_r) ? fid_ext : frame_fid_ext;
        tot_req.rd_en   = (tot_req.rd_addr < NF);
        state_nxt       = S_TOT_ADD;
      end

      S_TOT_ADD: begin
        tot_req.wr_en = (tgt_ext < NF);
        state_nxt     = S_FIN_RD;
        if (op_r == OP_END && !phase_r) begin
          count_nxt = cnt_m1;
          if (cnt_m1 != '0) begin
            stk_re    = 1'b1;
            stk_raddr = cnt_m2[SW-1:0];
            phase_nxt = 1'b1;
            state_nxt = S_STK_USE;
          end
        end
      end

      S_FIN_RD: begin
        tot_req.rd_addr = fid_ext;
        tot_req.rd_en   = (fid_ext < NF);
        state_nxt       = S_FIN_OUT;
      end

      S_FIN_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.total_time = (fid_ext < NF) ? tot_rd_data : '0;
          out_data_nxt.status     = status_r;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    op_r       <= op_nxt;
    fid_r      <= fid_nxt;
    t_r        <= t_nxt;
    status_r   <= status_nxt;
    phase_r    <= phase_nxt;
    tgt_r      <= tgt_nxt;
    delta_r    <= delta_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q_r <= stk_mem[stk_raddr];
    end
  end

endmodule

// ===== tb/call_stack_exclusive_time_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for call_stack_exclusive_time: drives trace events,
// predicts per-function exclusive totals and checks every result.
// Depends on cset_pkg and the call_stack_exclusive_time RTL.
module call_stack_exclusive_time_tb;
  import cset_pkg::*;

  localparam int NUM_FUNCS   = DEF_NUM_FUNCS;
  localparam int STACK_DEPTH = DEF_STACK_DEPTH;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_AFTER  = 600;
  localparam int HOLD_CYCLES = 400;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
  // opcode with no meaning; the block treats it as a read
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

  // Tracks the call stack and totals, queues the expected result per event.
  class profile_scoreboard;
    int        frame_func [STACK_DEPTH];
    longint    frame_start[STACK_DEPTH];
    int        depth;
    longint    totals[NUM_FUNCS];
    out_item_t expected_totals[$];
    int        errors;

    function new();
      depth  = 0;
      errors = 0;
      foreach (totals[i]) totals[i] = 0;
    endfunction

    function void charge(int fid, longint delta);
      longint v;
      v = totals[fid] + delta;
      if (v > TOTAL_MAX) v = TOTAL_MAX;
      if (v < TOTAL_MIN) v = TOTAL_MIN;
      totals[fid] = v;
    endfunction

    function void note_event(in_item_t it);
      longint             tm;
      logic [STATUS_W-1:0] st;
      out_item_t          exp_item;
      tm = {33'd0, it.event_time};
      st = ST_OK;
      case (it.opcode)
        OP_START: begin
          if (depth >= STACK_DEPTH) begin
            st = ST_FULL;
          end else begin
            if (depth > 0) charge(frame_func[depth-1], tm - frame_start[depth-1]);
            frame_func[depth]  = it.func_id;
            frame_start[depth] = tm;
            depth++;
          end
        end
        OP_END: begin
          if (depth == 0) begin
            st = ST_EMPTY;
          end else begin
            charge(it.func_id, tm - frame_start[depth-1] + 1);
            depth--;
            // parent's end charges from its start; take back its span up to now
            if (depth > 0) charge(frame_func[depth-1], -(tm - frame_start[depth-1] + 1));
          end
        end
        default: ;  // read, and the unused opcode acts as a read
      endcase
      exp_item.total_time = TOTAL_W'(totals[it.func_id]);
      exp_item.status     = st;
      expected_totals.push_back(exp_item);
    endfunction

    function void check_total(out_item_t got);
      out_item_t exp_item;
      if (expected_totals.size() == 0) begin
        $error("result with no transaction pending: total_time %0d status %0d",
               got.total_time, got.status);
        errors++;
        return;
      end
      exp_item = expected_totals.pop_front();
      if (got.total_time !== exp_item.total_time) begin
        $error("total_time: expected %0d, got %0d", exp_item.total_time, got.total_time);
        errors++;
      end
      if (got.status !== exp_item.status) begin
        $error("status: expected %0d, got %0d", exp_item.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  profile_scoreboard sb = new();
  bit          idle_on;
  int          results_seen = 0;

  call_stack_exclusive_time DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_event(it);
  endtask

  task automatic send_event(logic [OPCODE_W-1:0] op, int fid, longint tm);
    in_item_t it;
    it.opcode     = op;
    it.func_id    = FID_W'(fid);
    it.event_time = TIME_W'(tm);
    send_item(it);
  endtask

  // stop offering, then wait until every expected result has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_totals.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_event(OP_READ, 0, 0);
    send_event(OP_END, 63, T_MAX);         // end on empty stack
    send_event(OP_SPARE, 5, 0);            // unused opcode reads
    send_event(OP_START, 1, 0);
    send_event(OP_START, 2, 100);
    send_event(OP_START, 63, T_MAX);
    send_event(OP_END, 63, T_MAX);
    send_event(OP_START, 3, 5);            // time going backwards
    send_event(OP_END, 3, 2);
    send_event(OP_END, 7, 50);             // end names another function
    send_event(OP_END, 1, 200);
    send_event(OP_END, 0, 300);
    send_event(OP_READ, 1, T_MAX);
    send_event(OP_READ, 2, 0);
    send_event(OP_READ, 7, 0);
    send_event(OP_SPARE, 63, T_MAX);
    send_event(OP_START, 42, 31'h5555_5555);
    send_event(OP_START, 21, 31'h2AAA_AAAA);
    send_event(OP_END, 21, 31'h5555_5555);
    send_event(OP_END, 42, 31'h2AAA_AAAA);
    send_event(OP_READ, 42, 31'h5555_5555);
    send_event(OP_READ, 21, 31'h2AAA_AAAA);
  endtask

  // push past the top of the stack, then pop past the bottom
  task automatic run_stack_limits();
    for (int i = 0; i < STACK_DEPTH + 2; i++) send_event(OP_START, i, 1000 * i);
    send_event(OP_READ, 0, 0);
    for (int i = 0; i < STACK_DEPTH + 1; i++) begin
      if (sb.depth > 0 && i % 4 != 0)
        send_event(OP_END, sb.frame_func[sb.depth-1], 100000 + 1000 * i);
      else
        send_event(OP_END, $urandom_range(0, 63), 100000 + 1000 * i);
    end
  endtask

  task automatic run_random_trace(int n_items);
    in_item_t    it;
    int          sel;
    int          start_pct;
    int unsigned tnow;
    tnow = $urandom;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == n_items / 2) wait_for_drain();
      if ($urandom_range(0, 99) < 10) begin
        it.opcode     = OPCODE_W'($urandom_range(0, 3));
        it.func_id    = FID_W'($urandom);
        it.event_time = TIME_W'($urandom);
      end else begin
        sel       = $urandom_range(0, 99);
        start_pct = (sb.depth < 3) ? 65 : (sb.depth > 40) ? 30 : 45;
        tnow += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1 << 24)
                                             : $urandom_range(0, 500);
        it.event_time = TIME_W'(tnow);
        if (sel < 10) begin
          it.opcode  = OP_READ;
          it.func_id = FID_W'($urandom_range(0, 9));
        end else if (sel < 10 + start_pct) begin
          it.opcode  = OP_START;
          it.func_id = ($urandom_range(0, 4) != 0) ? FID_W'($urandom_range(0, 7))
                                                   : FID_W'($urandom);
        end else begin
          it.opcode  = OP_END;
          it.func_id = (sb.depth > 0 && $urandom_range(0, 99) < 85)
                     ? FID_W'(sb.frame_func[sb.depth-1]) : FID_W'($urandom_range(0, 7));
        end
      end
      send_item(it);
    end
  endtask

  // result side: random back-pressure, plus one long hold-off
  initial begin : result_sink
    int stall;
    bit held;
    stall     = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = gap_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      sb.check_total(out_data);
      results_seen++;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_on      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_for_drain();
    idle_on = 1'b1;
    run_stack_limits();
    wait_for_drain();
    run_random_trace(1750);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cset_pkg.sv
src/cset_totals.sv
src/call_stack_exclusive_time.sv
tb/call_stack_exclusive_time_tb.sv
